// ----- rtl/sbh_pkg.sv -----
// Package for the SHA-256 byte stream hasher: beat types, round constants
// and the SHA-256 mixing functions. No dependencies.
package sbh_pkg;

  localparam int unsigned FifoDepthDef = 4;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_bits_255_192;
    logic [63:0] digest_bits_191_128;
    logic [63:0] digest_bits_127_64;
    logic [63:0] digest_bits_63_0;
  } out_item_t;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] sml0(input logic [31:0] x);
    sml0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml1(input logic [31:0] x);
    sml1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      case (t)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
        6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
        6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      round_k = k;
    end
  endfunction

endpackage

// ----- rtl/sbh_front.sv -----
// Front end of the hasher: accepts input beats and queues them for the core.
// Depends on sbh_pkg.
module sbh_front import sbh_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output in_item_t item_o,
  output logic     empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/sbh_core.sv -----
// Back end of the hasher: block window, padding sequencer and one round unit.
// Depends on sbh_pkg.
module sbh_core import sbh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  logic      empty_i,
  output logic      pop_o,
  input  logic      res_free_i,
  output logic      emit_o,
  output out_item_t digest_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StRnd  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [5:0]  cnt_q, cnt_d, rnd_q, rnd_d;
  logic [63:0] len_q, len_d;
  logic        pad_q, pad_d, mark_q, mark_d, zone_q, zone_d;
  logic        final_q, final_d, eom_q, eom_d;
  logic        shift_en;
  logic [7:0]  shift_byte, pad_byte, len_byte;
  logic [31:0] sum1, sum2, new_w;

  // byte loader: the window shifts left one byte, new byte enters at the bottom
  assign len_byte = len_q[{~cnt_q[2:0], 3'b000} +: 8];
  assign pad_byte = !mark_q ? PadMark : ((cnt_q >= 6'd56 && zone_q) ? len_byte : 8'h00);

  assign sum1 = v_q[7] + big1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
              + round_k(rnd_q) + win_q[15];
  assign sum2 = big0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign new_w = win_q[15] + sml0(win_q[14]) + win_q[6] + sml1(win_q[1]);

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    h_d        = h_q;
    v_d        = v_q;
    cnt_d      = cnt_q;
    rnd_d      = rnd_q;
    len_d      = len_q;
    pad_d      = pad_q;
    mark_d     = mark_q;
    zone_d     = zone_q;
    final_d    = final_q;
    eom_d      = eom_q;
    pop_o      = 1'b0;
    emit_o     = 1'b0;
    shift_en   = 1'b0;
    shift_byte = item_i.message_byte;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          eom_d = item_i.end_of_message;
          pad_d = 1'b0;
          if (item_i.byte_present) begin
            shift_en = 1'b1;
            if (cnt_q == 6'd63) begin
              state_d = StRnd;
            end else if (item_i.end_of_message) begin
              state_d = StPad;
              pad_d   = 1'b1;
              mark_d  = 1'b0;
            end
          end else if (item_i.end_of_message) begin
            state_d = StPad;
            pad_d   = 1'b1;
            mark_d  = 1'b0;
          end
        end
      end
      StPad: begin
        shift_en   = 1'b1;
        shift_byte = pad_byte;
        if (!mark_q) begin
          // fold the pending bytes into the total length on the mark beat
          len_d  = len_q + {55'd0, cnt_q, 3'b000};
          mark_d = 1'b1;
          zone_d = (cnt_q < 6'd56);
        end
        if (cnt_q == 6'd63) begin
          final_d = mark_q ? zone_q : 1'b0;
          state_d = StRnd;
        end
      end
      StRnd: begin
        v_d[7] = v_q[6]; v_d[6] = v_q[5]; v_d[5] = v_q[4]; v_d[4] = v_q[3] + sum1;
        v_d[3] = v_q[2]; v_d[2] = v_q[1]; v_d[1] = v_q[0]; v_d[0] = sum1 + sum2;
        for (int i = 15; i > 0; i--) begin
          win_d[i] = win_q[i-1];
        end
        win_d[0] = new_w;
        rnd_d    = rnd_q + 1'b1;
        if (rnd_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (!pad_q) begin
          len_d   = len_q + BlockBits;
          state_d = eom_q ? StPad : StIdle;
          if (eom_q) begin
            pad_d  = 1'b1;
            mark_d = 1'b0;
          end
        end else begin
          state_d = final_q ? StOut : StPad;
          zone_d  = 1'b1;
        end
      end
      StOut: begin
        if (res_free_i) begin
          emit_o  = 1'b1;
          for (int i = 0; i < 8; i++) begin
            h_d[i] = InitH[255-32*i -: 32];
          end
          len_d   = '0;
          cnt_d   = '0;
          pad_d   = 1'b0;
          final_d = 1'b0;
          eom_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (shift_en) begin
      for (int i = 15; i > 0; i--) begin
        win_d[i] = {win_q[i][23:0], win_q[i-1][31:24]};
      end
      win_d[0] = {win_q[0][23:0], shift_byte};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == 6'd63) begin
        rnd_d = '0;
        v_d   = h_q;
      end
    end
  end

  assign digest_o.digest_bits_255_192 = {h_q[0], h_q[1]};
  assign digest_o.digest_bits_191_128 = {h_q[2], h_q[3]};
  assign digest_o.digest_bits_127_64  = {h_q[4], h_q[5]};
  assign digest_o.digest_bits_63_0    = {h_q[6], h_q[7]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      rnd_q   <= '0;
      len_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      zone_q  <= 1'b0;
      final_q <= 1'b0;
      eom_q   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitH[255-32*i -: 32];
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      len_q   <= len_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      zone_q  <= zone_d;
      final_q <= final_d;
      eom_q   <= eom_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
  end

endmodule

// ----- rtl/sha256_byte_stream_hasher_top.sv -----
// SHA-256 byte stream hasher. The core loads byte beats one at a time; each full
// 64-byte block then takes 64 rounds on the one round unit plus the chaining add.
// The core takes no new beats while the shared round unit works on a block; finishing
// pads byte by byte up to the block end, compresses each padded block, then shows.
// Reset (rst_ni low, asynchronous) empties the queue, drops any result and loads the
// initial hash values.
module sha256_byte_stream_hasher_top import sbh_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_item_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);
  in_item_t  q_item;
  logic      q_empty, q_pop;
  logic      emit;
  out_item_t digest;
  logic      res_valid_q, res_valid_d;
  out_item_t res_q;

  // front: hold incoming beats until the core is ready for them
  sbh_front #(.Depth(FifoDepth)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (in_item_i),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  // back: load bytes, pad, compress, produce the digest
  sbh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (q_item),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .res_free_i (!res_valid_q),
    .emit_o     (emit),
    .digest_o   (digest)
  );

  // result register: hold the digest until popped; the core keeps taking beats meanwhile
  always_comb begin
    res_valid_d = res_valid_q;
    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    if (emit) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= digest;
    end
  end

  assign empty_o    = !res_valid_q;
  assign out_item_o = res_q;

`ifndef SYNTH
  // the core only hands over a digest into a free result slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !res_valid_q) else $error("digest emitted over a pending result");

  // a waiting result stays until it is popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !pop_i |=> res_valid_q) else $error("result dropped without pop");

  // the core never pulls from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("core popped an empty queue");
`endif

endmodule
